// ===== src/pic_pkg.sv =====
// shared types and address map constants of the platform interrupt controller
package pic_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RAISE = 2'd2
    } func_t;

    localparam logic [25:0] PEND_BASE = 26'h000_1000;
    localparam logic [25:0] EN_BASE   = 26'h000_2000;
    localparam logic [25:0] CTX_BASE  = 26'h020_0000;

    localparam logic [11:0] CTX_THR_OFF   = 12'h000;
    localparam logic [11:0] CTX_CLAIM_OFF = 12'h004;

    localparam int OFFSET_W = 26;
    localparam int DATA_W   = 32;
    localparam int SOURCE_W = 6;
    localparam int IRQ_W    = 4;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

endpackage

// ===== src/platform_interrupt_controller_top.sv =====
// top level of the platform interrupt controller
// flow: every item ends with a scan of all sources for the irq lines; a priority read
//   first reads its entry, and a claim read first scans all sources for the best claim
// throughput: one item at a time; each item scans every source once through the single
//   read port of the priority memory (twice for a claim); done waits for the output
// reset: asynchronous; clears pending, enables, thresholds, output; priorities read zero
module platform_interrupt_controller_top #(
    parameter int NUM_SOURCES   = 64,
    parameter int NUM_HARTS     = 4,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // offset, wdata, source
    input  logic [pic_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rdata, irq_lines, zero fill
    output logic [pic_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import pic_pkg::*;

    localparam int SRC_W  = $clog2(NUM_SOURCES);
    localparam int CNT_W  = SRC_W + 1;
    localparam int WORDS  = (NUM_SOURCES + 31) / 32;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int HART_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
    localparam int EN_W   = WORDS * 32;
    localparam int PRIO_SPAN = 4 * NUM_SOURCES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRD,
        ST_CLAIM,
        ST_IRQ,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [NUM_SOURCES-1:0]   pend_reg, pend_next;
    logic [EN_W-1:0]          en_reg [NUM_HARTS];
    logic [EN_W-1:0]          en_next [NUM_HARTS];
    logic [PRIORITY_BITS-1:0] thr_reg [NUM_HARTS];
    logic [PRIORITY_BITS-1:0] thr_next [NUM_HARTS];
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pvld_reg, pvld_next;
    logic [SRC_W-1:0]         pidx_reg, pidx_next;
    logic [NUM_HARTS-1:0]     acc_reg, acc_next;
    logic [HART_W-1:0]        claim_h_reg, claim_h_next;
    logic [SRC_W-1:0]         best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [DATA_W-1:0]        res_rdata_reg, res_rdata_next;
    logic [IRQ_W-1:0]         res_irq_reg, res_irq_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_rdata_reg, out_rdata_next;
    logic [IRQ_W-1:0]         out_irq_reg, out_irq_next;

    logic [OFFSET_W-1:0]      off;
    logic [DATA_W-1:0]        wdata;
    logic [SOURCE_W-1:0]      src;
    func_t                    func;
    logic                     accept;
    logic                     is_prio, is_pend, is_en, is_ctx, w_ok, src_ok;
    logic [WORD_W-1:0]        wi;
    logic [HART_W-1:0]        en_h, ctx_h;
    logic [SRC_W-1:0]         prio_idx, raise_idx;
    logic [11:0]              ctx_off;
    logic [EN_W-1:0]          pend_pad;

    logic                     wr_en;
    logic [SRC_W-1:0]         rd_addr;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic                     issuing;
    logic [NUM_HARTS-1:0]     elig;
    logic                     celig;

    pic_prio_store #(
        .DEPTH (NUM_SOURCES),
        .WIDTH (PRIORITY_BITS)
    ) u_prio_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (prio_idx),
        .wr_data (wdata[PRIORITY_BITS-1:0]),
        .rd_addr (rd_addr),
        .rd_prio (rd_prio)
    );

    assign off   = s_axis_tdata[25:0];
    assign wdata = s_axis_tdata[57:26];
    assign src   = s_axis_tdata[63:58];
    assign func  = func_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_prio   = off < OFFSET_W'(PRIO_SPAN);
    assign is_pend   = off[25:7] == PEND_BASE[25:7];
    assign is_en     = (off[25:12] == EN_BASE[25:12]) && (off[11:7] < 5'(NUM_HARTS));
    assign is_ctx    = (off[25:16] == CTX_BASE[25:16]) && (off[15:12] < 4'(NUM_HARTS));
    assign w_ok      = {1'b0, off[6:2]} < 6'(WORDS);
    assign wi        = off[2 +: WORD_W];
    assign en_h      = off[7 +: HART_W];
    assign ctx_h     = off[12 +: HART_W];
    assign ctx_off   = off[11:0];
    assign prio_idx  = off[2 +: SRC_W];
    assign src_ok    = (src != '0) && (32'(src) < NUM_SOURCES);
    assign raise_idx = SRC_W'(src);
    assign pend_pad  = EN_W'(pend_reg);

    assign issuing = cnt_reg < CNT_W'(NUM_SOURCES);

    always_comb
    begin
        for (int h = 0; h < NUM_HARTS; h++)
        begin
            elig[h] = pend_reg[pidx_reg] && en_reg[h][pidx_reg] && (rd_prio > thr_reg[h]);
        end
        celig = pend_reg[pidx_reg] && en_reg[claim_h_reg][pidx_reg]
                && (rd_prio > best_prio_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        en_next        = en_reg;
        thr_next       = thr_reg;
        cnt_next       = cnt_reg;
        pvld_next      = pvld_reg;
        pidx_next      = pidx_reg;
        acc_next       = acc_reg;
        claim_h_next   = claim_h_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        res_rdata_next = res_rdata_reg;
        res_irq_next   = res_irq_reg;
        out_valid_next = out_valid_reg;
        out_rdata_next = out_rdata_reg;
        out_irq_next   = out_irq_reg;
        wr_en          = 1'b0;
        rd_addr        = prio_idx;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_rdata_next = '0;
                    cnt_next       = '0;
                    pvld_next      = 1'b0;
                    acc_next       = '0;
                    state_next     = ST_IRQ;
                    unique case (func)
                        FUNC_READ:
                        begin
                            if (is_prio)
                            begin
                                state_next = ST_PRD;
                            end
                            else if (is_pend)
                            begin
                                if (w_ok)
                                begin
                                    res_rdata_next = pend_pad[{wi, 5'd0} +: 32];
                                end
                            end
                            else if (is_en)
                            begin
                                if (w_ok)
                                begin
                                    res_rdata_next = en_reg[en_h][{wi, 5'd0} +: 32];
                                end
                            end
                            else if (is_ctx)
                            begin
                                if (ctx_off == CTX_THR_OFF)
                                begin
                                    res_rdata_next = DATA_W'(thr_reg[ctx_h]);
                                end
                                else if (ctx_off == CTX_CLAIM_OFF)
                                begin
                                    claim_h_next   = ctx_h;
                                    best_prio_next = thr_reg[ctx_h];
                                    best_id_next   = '0;
                                    state_next     = ST_CLAIM;
                                end
                            end
                        end
                        FUNC_WRITE:
                        begin
                            if (is_prio)
                            begin
                                wr_en = (prio_idx != '0);
                            end
                            else if (is_en)
                            begin
                                if (w_ok)
                                begin
                                    en_next[en_h][{wi, 5'd0} +: 32] = wdata;
                                end
                            end
                            else if (is_ctx && (ctx_off == CTX_THR_OFF))
                            begin
                                thr_next[ctx_h] = wdata[PRIORITY_BITS-1:0];
                            end
                        end
                        FUNC_RAISE:
                        begin
                            if (src_ok)
                            begin
                                pend_next[raise_idx] = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PRD:
            begin
                res_rdata_next = DATA_W'(rd_prio);
                state_next     = ST_IRQ;
            end
            ST_CLAIM, ST_IRQ:
            begin
                rd_addr = cnt_reg[SRC_W-1:0];
                if (issuing)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                pvld_next = issuing;
                pidx_next = cnt_reg[SRC_W-1:0];
                if (pvld_reg)
                begin
                    if (state_reg == ST_IRQ)
                    begin
                        acc_next = acc_reg | elig;
                    end
                    else if (celig)
                    begin
                        best_id_next   = pidx_reg;
                        best_prio_next = rd_prio;
                    end
                end
                if (!issuing && !pvld_reg)
                begin
                    if (state_reg == ST_CLAIM)
                    begin
                        if (best_id_reg != '0)
                        begin
                            pend_next[best_id_reg] = 1'b0;
                        end
                        res_rdata_next = DATA_W'(best_id_reg);
                        cnt_next       = '0;
                        state_next     = ST_IRQ;
                    end
                    else
                    begin
                        res_irq_next = IRQ_W'(acc_reg);
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rdata_next = res_rdata_reg;
                    out_irq_next   = res_irq_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= '0;
            for (int h = 0; h < NUM_HARTS; h++)
            begin
                en_reg[h]  <= '0;
                thr_reg[h] <= '0;
            end
            cnt_reg       <= '0;
            pvld_reg      <= 1'b0;
            pidx_reg      <= '0;
            acc_reg       <= '0;
            claim_h_reg   <= '0;
            best_id_reg   <= '0;
            best_prio_reg <= '0;
            res_rdata_reg <= '0;
            res_irq_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_rdata_reg <= '0;
            out_irq_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            en_reg        <= en_next;
            thr_reg       <= thr_next;
            cnt_reg       <= cnt_next;
            pvld_reg      <= pvld_next;
            pidx_reg      <= pidx_next;
            acc_reg       <= acc_next;
            claim_h_reg   <= claim_h_next;
            best_id_reg   <= best_id_next;
            best_prio_reg <= best_prio_next;
            res_rdata_reg <= res_rdata_next;
            res_irq_reg   <= res_irq_next;
            out_valid_reg <= out_valid_next;
            out_rdata_reg <= out_rdata_next;
            out_irq_reg   <= out_irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - DATA_W - IRQ_W)'(0), out_irq_reg, out_rdata_reg};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input taken again right after an item");

    a_src0_never_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_reg[0])
        else $error("source zero marked pending");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NUM_SOURCES))
        else $error("scan counter ran past the last source");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished scan");

endmodule

// ===== src/pic_prio_store.sv =====
// source priority memory with per-entry valid bits and registered read
module pic_prio_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 3,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_prio
);

    logic [WIDTH-1:0] prio_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= prio_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // entries never written read as zero
    assign rd_prio = rd_vld_reg ? rd_data_reg : '0;

endmodule
